FILE: rtl/ffa_pkg.sv
package ffa_pkg;

  localparam int HeaderBytes = 32;
  localparam int MinSplit    = 16;
  localparam int ArenaMax    = 65536;
  localparam int AddrSpace   = 65536;
  localparam int MaxBlocks   = 64;
  localparam int ArenaLimit  = (ArenaMax < AddrSpace) ? ArenaMax : AddrSpace;
  localparam int IdxW        = $clog2(MaxBlocks);
  localparam int CntW        = $clog2(MaxBlocks + 1);
  localparam int EntW        = 33;

  typedef enum logic [1:0] {
    ACT_INIT    = 2'd0,
    ACT_ALLOC   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_RESIZE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT_WR,
    OP_SCAN_RD,
    OP_CK_FIT,
    OP_CK_ADDR,
    OP_CK_START,
    OP_ALLOC,
    OP_INS_RD,
    OP_INS_WB,
    OP_INS_WR,
    OP_REL_BEGIN,
    OP_BK_RD,
    OP_BK_CK,
    OP_FW_RD,
    OP_FW_CK,
    OP_MERGE_WR,
    OP_RM_RD,
    OP_RM_WB,
    OP_GROW_BEGIN,
    OP_GROW_WR,
    OP_GROW_TAIL,
    OP_MOVE_BEGIN,
    OP_SCAN0,
    OP_SHRINK_RD,
    OP_SHRINK_CK,
    OP_SHRINK_WI,
    OP_KEEP,
    OP_SET_UNK,
    OP_SET_NOSP
  } op_e;

  typedef struct packed {
    logic        used;
    logic [15:0] size;
    logic [15:0] start;
  } ent_t;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    action_e act;
    logic    k_end;
    logic    hit;
    logic    rd_free;
    logic    l_zero;
    logic    ins_at;
    logic    rm_end;
    logic    split_a;
    logic    full;
    logic    fit_in;
    logic    split_g;
    logic    nxt_free;
    logic    req_zero;
    logic    adr_zero;
    logic    req_gt;
    logic    req_lt;
    logic    shr_split;
  } flags_t;

endpackage

FILE: rtl/first_fit_arena_allocator.sv
// First-fit arena allocator. A command is taken when start is high and busy is low; its one
// result word is on the result ports when done_o is high for exactly one cycle, and the
// receiver cannot stall it. The block table sits in a memory with one write port and one
// registered read port, so every walk over the table reads one entry at a time; a moving
// resize walks it for search, insert, search, coalesce and compaction. After reset the
// block is busy for one cycle while it writes the initial free block. The arena size
// register is written through the APB port at offset 0.
module first_fit_arena_allocator
  import ffa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [15:0] address_i,
  input  logic [15:0] request_size_i,
  output logic        done_o,
  output logic [15:0] result_address_o,
  output logic [15:0] granted_size_o,
  output logic [1:0]  status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [16:0] arena_q, arena_d;
  cmd_t        cmd;
  flags_t      flags;

  assign pready = 1'b1;

  always_comb begin
    arena_d = arena_q;
    if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      arena_d = pwdata[16:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q <= 17'(AddrSpace);
    end else begin
      arena_q <= arena_d;
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {15'd0, arena_q} : 32'd0;

  ffa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .flags_i (flags),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  ffa_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .action_i         (action_i),
    .address_i        (address_i),
    .request_size_i   (request_size_i),
    .arena_i          (arena_q),
    .flags_o          (flags),
    .result_address_o (result_address_o),
    .granted_size_o   (granted_size_o),
    .status_o         (status_o)
  );

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result word outside a command");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (result_address_o == '0 && granted_size_o == '0))
    else $error("failed command reports an address or size");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o)) else $error("accepted command did not start");

endmodule

FILE: rtl/ffa_ram.sv
module ffa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/ffa_ctrl.sv
module ffa_ctrl
  import ffa_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  flags_t flags_i,
  output cmd_t   cmd_o,
  output logic   busy_o,
  output logic   done_o
);

  localparam logic [5:0] S_RST     = 6'd0;
  localparam logic [5:0] S_IDLE    = 6'd1;
  localparam logic [5:0] S_DISP    = 6'd2;
  localparam logic [5:0] S_INIT    = 6'd3;
  localparam logic [5:0] S_FIT_RD  = 6'd4;
  localparam logic [5:0] S_FIT_CK  = 6'd5;
  localparam logic [5:0] S_NOSP    = 6'd6;
  localparam logic [5:0] S_ALLOC   = 6'd7;
  localparam logic [5:0] S_INS_RD  = 6'd8;
  localparam logic [5:0] S_INS_WB  = 6'd9;
  localparam logic [5:0] S_INS_WR  = 6'd10;
  localparam logic [5:0] S_MV0     = 6'd11;
  localparam logic [5:0] S_ST_RD   = 6'd12;
  localparam logic [5:0] S_ST_CK   = 6'd13;
  localparam logic [5:0] S_ADR_RD  = 6'd14;
  localparam logic [5:0] S_ADR_CK  = 6'd15;
  localparam logic [5:0] S_UNK     = 6'd16;
  localparam logic [5:0] S_RESOLVE = 6'd17;
  localparam logic [5:0] S_KEEP    = 6'd18;
  localparam logic [5:0] S_REL     = 6'd19;
  localparam logic [5:0] S_BK_RD   = 6'd20;
  localparam logic [5:0] S_BK_CK   = 6'd21;
  localparam logic [5:0] S_FW_RD   = 6'd22;
  localparam logic [5:0] S_FW_CK   = 6'd23;
  localparam logic [5:0] S_MERGE   = 6'd24;
  localparam logic [5:0] S_RM_RD   = 6'd25;
  localparam logic [5:0] S_RM_WB   = 6'd26;
  localparam logic [5:0] S_GROW    = 6'd27;
  localparam logic [5:0] S_GDEC    = 6'd28;
  localparam logic [5:0] S_GWR     = 6'd29;
  localparam logic [5:0] S_GTAIL   = 6'd30;
  localparam logic [5:0] S_MOVE    = 6'd31;
  localparam logic [5:0] S_SHR_RD  = 6'd32;
  localparam logic [5:0] S_SHR_CK  = 6'd33;
  localparam logic [5:0] S_SHR_WM  = 6'd34;
  localparam logic [5:0] S_SHR_WI  = 6'd35;
  localparam logic [5:0] S_FIN     = 6'd36;

  logic [5:0] state_q, state_d;
  logic       mv_q, mv_d;
  logic       gr_q, gr_d;
  logic       fw_done;

  assign fw_done = gr_q;

  always_comb begin
    state_d   = state_q;
    mv_d      = mv_q;
    gr_d      = gr_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      S_RST: begin
        cmd_o.op = OP_INIT_WR;
        state_d  = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_LOAD;
          mv_d     = 1'b0;
          gr_d     = 1'b0;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        unique case (flags_i.act)
          ACT_INIT:    state_d = S_INIT;
          ACT_ALLOC:   state_d = S_FIT_RD;
          ACT_RELEASE: state_d = flags_i.adr_zero ? S_FIN : S_ADR_RD;
          ACT_RESIZE: begin
            if (!flags_i.adr_zero) begin
              state_d = S_ADR_RD;
            end else begin
              state_d = flags_i.req_zero ? S_FIN : S_FIT_RD;
            end
          end
          default: state_d = S_FIN;
        endcase
      end
      S_INIT: begin
        cmd_o.op = OP_INIT_WR;
        state_d  = S_FIN;
      end
      S_FIT_RD: begin
        cmd_o.op = OP_SCAN_RD;
        state_d  = flags_i.k_end ? S_NOSP : S_FIT_CK;
      end
      S_FIT_CK: begin
        cmd_o.op = OP_CK_FIT;
        state_d  = flags_i.hit ? S_ALLOC : S_FIT_RD;
      end
      S_NOSP: begin
        cmd_o.op = OP_SET_NOSP;
        state_d  = S_FIN;
      end
      S_ALLOC: begin
        cmd_o.op = OP_ALLOC;
        if (flags_i.split_a) begin
          state_d = flags_i.full ? S_FIN : S_INS_RD;
        end else begin
          state_d = mv_q ? S_MV0 : S_FIN;
        end
      end
      S_INS_RD: begin
        cmd_o.op = OP_INS_RD;
        state_d  = flags_i.ins_at ? S_INS_WR : S_INS_WB;
      end
      S_INS_WB: begin
        cmd_o.op = OP_INS_WB;
        state_d  = S_INS_RD;
      end
      S_INS_WR: begin
        cmd_o.op = OP_INS_WR;
        state_d  = mv_q ? S_MV0 : S_FIN;
      end
      S_MV0: begin
        cmd_o.op = OP_SCAN0;
        state_d  = S_ST_RD;
      end
      S_ST_RD: begin
        cmd_o.op = OP_SCAN_RD;
        state_d  = flags_i.k_end ? S_FIN : S_ST_CK;
      end
      S_ST_CK: begin
        cmd_o.op = OP_CK_START;
        state_d  = flags_i.hit ? S_REL : S_ST_RD;
      end
      S_ADR_RD: begin
        cmd_o.op = OP_SCAN_RD;
        state_d  = flags_i.k_end ? S_UNK : S_ADR_CK;
      end
      S_ADR_CK: begin
        cmd_o.op = OP_CK_ADDR;
        state_d  = flags_i.hit ? S_RESOLVE : S_ADR_RD;
      end
      S_UNK: begin
        cmd_o.op = OP_SET_UNK;
        state_d  = S_FIN;
      end
      S_RESOLVE: begin
        priority if (flags_i.act == ACT_RELEASE || flags_i.req_zero) begin
          state_d = S_REL;
        end else if (flags_i.req_gt) begin
          state_d = S_GROW;
        end else if (flags_i.req_lt && flags_i.shr_split) begin
          state_d = S_SHR_RD;
        end else begin
          state_d = S_KEEP;
        end
      end
      S_KEEP: begin
        cmd_o.op = OP_KEEP;
        state_d  = S_FIN;
      end
      S_REL: begin
        cmd_o.op = OP_REL_BEGIN;
        state_d  = S_BK_RD;
      end
      S_BK_RD: begin
        cmd_o.op = OP_BK_RD;
        state_d  = flags_i.l_zero ? S_FW_RD : S_BK_CK;
      end
      S_BK_CK: begin
        cmd_o.op = OP_BK_CK;
        state_d  = flags_i.rd_free ? S_BK_RD : S_FW_RD;
      end
      S_FW_RD: begin
        cmd_o.op = OP_FW_RD;
        if (flags_i.k_end) begin
          state_d = fw_done ? S_GDEC : S_MERGE;
        end else begin
          state_d = S_FW_CK;
        end
      end
      S_FW_CK: begin
        cmd_o.op = OP_FW_CK;
        if (flags_i.rd_free) begin
          state_d = S_FW_RD;
        end else begin
          state_d = fw_done ? S_GDEC : S_MERGE;
        end
      end
      S_MERGE: begin
        cmd_o.op = OP_MERGE_WR;
        state_d  = S_RM_RD;
      end
      S_RM_RD: begin
        cmd_o.op = OP_RM_RD;
        state_d  = flags_i.rm_end ? S_FIN : S_RM_WB;
      end
      S_RM_WB: begin
        cmd_o.op = OP_RM_WB;
        state_d  = S_RM_RD;
      end
      S_GROW: begin
        cmd_o.op = OP_GROW_BEGIN;
        gr_d     = 1'b1;
        state_d  = S_FW_RD;
      end
      S_GDEC: begin
        state_d = flags_i.fit_in ? S_GWR : S_MOVE;
      end
      S_GWR: begin
        cmd_o.op = OP_GROW_WR;
        state_d  = flags_i.split_g ? S_GTAIL : S_RM_RD;
      end
      S_GTAIL: begin
        cmd_o.op = OP_GROW_TAIL;
        state_d  = S_RM_RD;
      end
      S_MOVE: begin
        cmd_o.op = OP_MOVE_BEGIN;
        mv_d     = 1'b1;
        gr_d     = 1'b0;
        state_d  = S_FIT_RD;
      end
      S_SHR_RD: begin
        cmd_o.op = OP_SHRINK_RD;
        state_d  = S_SHR_CK;
      end
      S_SHR_CK: begin
        cmd_o.op = OP_SHRINK_CK;
        priority if (flags_i.nxt_free) begin
          state_d = S_SHR_WM;
        end else if (flags_i.full) begin
          state_d = S_FIN;
        end else begin
          state_d = S_SHR_WI;
        end
      end
      S_SHR_WM: begin
        cmd_o.op = OP_SHRINK_WI;
        state_d  = S_FIN;
      end
      S_SHR_WI: begin
        cmd_o.op = OP_SHRINK_WI;
        state_d  = S_INS_RD;
      end
      S_FIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RST;
      mv_q    <= 1'b0;
      gr_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mv_q    <= mv_d;
      gr_q    <= gr_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_FIN);

endmodule

FILE: rtl/ffa_dpath.sv
module ffa_dpath
  import ffa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [1:0]  action_i,
  input  logic [15:0] address_i,
  input  logic [15:0] request_size_i,
  input  logic [16:0] arena_i,
  output flags_t      flags_o,
  output logic [15:0] result_address_o,
  output logic [15:0] granted_size_o,
  output logic [1:0]  status_o
);

  localparam logic [16:0] Hdr17   = 17'(HeaderBytes);
  localparam logic [16:0] Split17 = 17'(HeaderBytes + MinSplit);
  localparam logic [15:0] Hdr16   = 16'(HeaderBytes);
  localparam logic [16:0] Lim17   = 17'(ArenaLimit);

  logic [CntW-1:0] cnt_q, cnt_d, k_q, k_d, i_q, i_d, l_q, l_d, m_q, m_d;
  logic [16:0]     acc_q, acc_d;
  logic [15:0]     ls_q, ls_d, es_q, es_d, ez_q, ez_d, req_q, req_d, adr_q, adr_d;
  logic [15:0]     old_q, old_d, raddr_q, raddr_d, rsize_q, rsize_d;
  action_e         act_q, act_d;
  status_e         st_q, st_d;
  ent_t            ins_q, ins_d;

  logic            we;
  logic [IdxW-1:0] wa, ra;
  ent_t            wd, rd;
  logic [EntW-1:0] rdata;

  logic [CntW-1:0] i1;
  logic [16:0]     req17, ez17, req48, acc_add, lim_a, init17;
  logic [15:0]     init_sz, tstart, diff;
  logic [CntW:0]   km;
  logic            fit_hit, addr_hit, start_hit;

  ffa_ram #(.Width(EntW), .Depth(MaxBlocks)) u_tbl (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wa),
    .wdata_i (wd),
    .raddr_i (ra),
    .rdata_o (rdata)
  );

  assign rd      = ent_t'(rdata);
  assign i1      = i_q + CntW'(1);
  assign req17   = {1'b0, req_q};
  assign ez17    = {1'b0, ez_q};
  assign req48   = req17 + Split17;
  assign acc_add = acc_q + {1'b0, rd.size} + Hdr17;
  assign lim_a   = (arena_i > Lim17) ? Lim17 : arena_i;
  assign init17  = (lim_a > Hdr17) ? (lim_a - Hdr17) : 17'd0;
  assign init_sz = init17[15:0];
  assign tstart  = es_q + Hdr16 + req_q;
  assign diff    = ez_q - req_q;
  assign km      = {1'b0, k_q} + {1'b0, m_q};

  assign fit_hit   = !rd.used && (rd.size >= req_q);
  assign addr_hit  = rd.used && (({1'b0, rd.start} + Hdr17) == {1'b0, adr_q});
  assign start_hit = rd.used && (rd.start == old_q);

  always_comb begin
    flags_o.act       = act_q;
    flags_o.k_end     = (k_q >= cnt_q);
    flags_o.hit       = (cmd_i.op == OP_CK_FIT) ? fit_hit :
                        (cmd_i.op == OP_CK_ADDR) ? addr_hit : start_hit;
    flags_o.rd_free   = !rd.used;
    flags_o.l_zero    = (l_q == '0);
    flags_o.ins_at    = (k_q == i1);
    flags_o.rm_end    = (km >= {1'b0, cnt_q});
    flags_o.split_a   = (ez17 >= req48);
    flags_o.full      = (cnt_q == CntW'(MaxBlocks));
    flags_o.fit_in    = (req17 <= acc_q);
    flags_o.split_g   = (acc_q >= req48);
    flags_o.nxt_free  = (i1 < cnt_q) && !rd.used;
    flags_o.req_zero  = (req_q == '0);
    flags_o.adr_zero  = (adr_q == '0);
    flags_o.req_gt    = (req_q > ez_q);
    flags_o.req_lt    = (req_q < ez_q);
    flags_o.shr_split = ({1'b0, diff} >= Split17);
  end

  always_comb begin
    cnt_d   = cnt_q;
    k_d     = k_q;
    i_d     = i_q;
    l_d     = l_q;
    m_d     = m_q;
    acc_d   = acc_q;
    ls_d    = ls_q;
    es_d    = es_q;
    ez_d    = ez_q;
    req_d   = req_q;
    adr_d   = adr_q;
    old_d   = old_q;
    act_d   = act_q;
    st_d    = st_q;
    raddr_d = raddr_q;
    rsize_d = rsize_q;
    ins_d   = ins_q;
    we      = 1'b0;
    wa      = i_q[IdxW-1:0];
    wd      = '{used: 1'b1, size: req_q, start: es_q};
    ra      = k_q[IdxW-1:0];
    unique case (cmd_i.op)
      OP_LOAD: begin
        act_d   = action_e'(action_i);
        adr_d   = address_i;
        req_d   = request_size_i;
        k_d     = '0;
        raddr_d = '0;
        rsize_d = '0;
        st_d    = ST_OK;
      end
      OP_INIT_WR: begin
        we      = 1'b1;
        wa      = '0;
        wd      = '{used: 1'b0, size: init_sz, start: 16'd0};
        cnt_d   = CntW'(1);
        rsize_d = init_sz;
      end
      OP_SCAN_RD: begin
        ra = k_q[IdxW-1:0];
      end
      OP_CK_FIT, OP_CK_ADDR, OP_CK_START: begin
        if (flags_o.hit) begin
          i_d  = k_q;
          es_d = rd.start;
          ez_d = rd.size;
        end else begin
          k_d = k_q + CntW'(1);
        end
      end
      OP_ALLOC: begin
        if (flags_o.split_a) begin
          if (flags_o.full) begin
            st_d = ST_FULL;
          end else begin
            we      = 1'b1;
            ins_d   = '{used: 1'b0, size: ez_q - req_q - Hdr16, start: tstart};
            k_d     = cnt_q;
            raddr_d = es_q + Hdr16;
            rsize_d = req_q;
          end
        end else begin
          we      = 1'b1;
          wd      = '{used: 1'b1, size: ez_q, start: es_q};
          raddr_d = es_q + Hdr16;
          rsize_d = ez_q;
        end
      end
      OP_INS_RD: begin
        ra = IdxW'(k_q - CntW'(1));
      end
      OP_INS_WB: begin
        we  = 1'b1;
        wa  = k_q[IdxW-1:0];
        wd  = rd;
        k_d = k_q - CntW'(1);
      end
      OP_INS_WR: begin
        we    = 1'b1;
        wa    = i1[IdxW-1:0];
        wd    = ins_q;
        cnt_d = cnt_q + CntW'(1);
      end
      OP_REL_BEGIN: begin
        acc_d = ez17;
        ls_d  = es_q;
        l_d   = i_q;
        k_d   = i1;
      end
      OP_BK_RD: begin
        ra = IdxW'(l_q - CntW'(1));
      end
      OP_BK_CK: begin
        if (!rd.used) begin
          acc_d = acc_add;
          ls_d  = rd.start;
          l_d   = l_q - CntW'(1);
        end
      end
      OP_FW_RD: begin
        ra = k_q[IdxW-1:0];
      end
      OP_FW_CK: begin
        if (!rd.used) begin
          acc_d = acc_add;
          k_d   = k_q + CntW'(1);
        end
      end
      OP_MERGE_WR: begin
        we  = 1'b1;
        wa  = l_q[IdxW-1:0];
        wd  = '{used: 1'b0, size: acc_q[15:0], start: ls_q};
        m_d = k_q - CntW'(1) - l_q;
        k_d = l_q + CntW'(1);
      end
      OP_RM_RD: begin
        if (flags_o.rm_end) begin
          cnt_d = cnt_q - m_q;
        end else begin
          ra = km[IdxW-1:0];
        end
      end
      OP_RM_WB: begin
        we  = 1'b1;
        wa  = k_q[IdxW-1:0];
        wd  = rd;
        k_d = k_q + CntW'(1);
      end
      OP_GROW_BEGIN: begin
        acc_d = ez17;
        k_d   = i1;
      end
      OP_GROW_WR: begin
        we      = 1'b1;
        raddr_d = es_q + Hdr16;
        if (flags_o.split_g) begin
          rsize_d = req_q;
        end else begin
          wd      = '{used: 1'b1, size: acc_q[15:0], start: es_q};
          rsize_d = acc_q[15:0];
        end
        m_d = k_q - CntW'(1) - i_q;
        k_d = i1;
      end
      OP_GROW_TAIL: begin
        we  = 1'b1;
        wa  = i1[IdxW-1:0];
        wd  = '{used: 1'b0, size: acc_q[15:0] - req_q - Hdr16, start: tstart};
        m_d = m_q - CntW'(1);
        k_d = k_q + CntW'(1);
      end
      OP_MOVE_BEGIN: begin
        old_d = es_q;
        k_d   = '0;
      end
      OP_SCAN0: begin
        k_d = '0;
      end
      OP_SHRINK_RD: begin
        ra = i1[IdxW-1:0];
      end
      OP_SHRINK_CK: begin
        if (flags_o.nxt_free) begin
          we = 1'b1;
          wa = i1[IdxW-1:0];
          wd = '{used: 1'b0, size: rd.size + diff, start: tstart};
        end else if (flags_o.full) begin
          st_d = ST_FULL;
        end else begin
          ins_d = '{used: 1'b0, size: diff - Hdr16, start: tstart};
          k_d   = cnt_q;
        end
      end
      OP_SHRINK_WI: begin
        we      = 1'b1;
        raddr_d = es_q + Hdr16;
        rsize_d = req_q;
      end
      OP_KEEP: begin
        raddr_d = es_q + Hdr16;
        rsize_d = ez_q;
      end
      OP_SET_UNK: begin
        st_d = ST_UNKNOWN;
      end
      OP_SET_NOSP: begin
        st_d = ST_NOSPACE;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CntW'(1);
      act_q <= ACT_INIT;
      st_q  <= ST_OK;
    end else begin
      cnt_q <= cnt_d;
      act_q <= act_d;
      st_q  <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    i_q     <= i_d;
    l_q     <= l_d;
    m_q     <= m_d;
    acc_q   <= acc_d;
    ls_q    <= ls_d;
    es_q    <= es_d;
    ez_q    <= ez_d;
    req_q   <= req_d;
    adr_q   <= adr_d;
    old_q   <= old_d;
    raddr_q <= raddr_d;
    rsize_q <= rsize_d;
    ins_q   <= ins_d;
  end

  assign result_address_o = raddr_q;
  assign granted_size_o   = rsize_q;
  assign status_o         = st_q;

endmodule
